/* hdl/im2col_pkg.sv */
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared types, register map and defaults of the im2col patch gather block.
// ----------------------------------------------------------------------------
`default_nettype none

package im2col_pkg;

   // Default storage limits
   localparam int DEF_MAX_ROWS     = 64;
   localparam int DEF_MAX_COLS     = 64;
   localparam int DEF_MAX_CHANNELS = 4;
   localparam int DEF_MAX_KERNEL   = 8;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROWS = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_COLS = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PAD_AMOUNT  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_OUT_ROWS    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_OUT_COLS    = 3'd7;

   // Command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_GATHER = 1'b1;

   // Signed image coordinate: covers row*stride - pad + kernel offset
   localparam int POS_W = 12;

   typedef struct packed {
      logic [6:0] image_rows;
      logic [6:0] image_cols;
      logic [3:0] kernel_rows;
      logic [3:0] kernel_cols;
      logic [2:0] pad_amount;
      logic [3:0] step_size;
      logic [7:0] out_rows;
      logic [7:0] out_cols;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      image_rows:  7'd64,
      image_cols:  7'd64,
      kernel_rows: 4'd3,
      kernel_cols: 4'd3,
      pad_amount:  3'd1,
      step_size:   4'd1,
      out_rows:    8'd64,
      out_cols:    8'd64
   };

   typedef struct packed {
      logic        command;
      logic [1:0]  channel;
      logic [6:0]  row_index;
      logic [6:0]  col_index;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_word;
      logic [5:0]  kernel_offset;
      logic [13:0] column_index;
      logic        is_padding;
      logic        request_error;
      logic        last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic issue;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free;
      logic elem_last;
   } ctrl_stat_type;

endpackage

`default_nettype wire

/* hdl/im2col_regs.sv */
// ----------------------------------------------------------------------------
// im2col_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_regs (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [im2col_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [im2col_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [im2col_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                      csr_pready,
   output im2col_pkg::cfg_type                       cfg
);

   im2col_pkg::cfg_type                  cfg_ff;
   im2col_pkg::cfg_type                  cfg_in;
   logic                                 wr_en;
   logic [im2col_pkg::REG_IDX_W-1:0]     reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[im2col_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            im2col_pkg::REG_IMAGE_ROWS:  cfg_in.image_rows  = csr_pwdata[6:0];
            im2col_pkg::REG_IMAGE_COLS:  cfg_in.image_cols  = csr_pwdata[6:0];
            im2col_pkg::REG_KERNEL_ROWS: cfg_in.kernel_rows = csr_pwdata[3:0];
            im2col_pkg::REG_KERNEL_COLS: cfg_in.kernel_cols = csr_pwdata[3:0];
            im2col_pkg::REG_PAD_AMOUNT:  cfg_in.pad_amount  = csr_pwdata[2:0];
            im2col_pkg::REG_STEP_SIZE:   cfg_in.step_size   = csr_pwdata[3:0];
            im2col_pkg::REG_OUT_ROWS:    cfg_in.out_rows    = csr_pwdata[7:0];
            im2col_pkg::REG_OUT_COLS:    cfg_in.out_cols    = csr_pwdata[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         im2col_pkg::REG_IMAGE_ROWS:  csr_prdata = 32'(cfg_ff.image_rows);
         im2col_pkg::REG_IMAGE_COLS:  csr_prdata = 32'(cfg_ff.image_cols);
         im2col_pkg::REG_KERNEL_ROWS: csr_prdata = 32'(cfg_ff.kernel_rows);
         im2col_pkg::REG_KERNEL_COLS: csr_prdata = 32'(cfg_ff.kernel_cols);
         im2col_pkg::REG_PAD_AMOUNT:  csr_prdata = 32'(cfg_ff.pad_amount);
         im2col_pkg::REG_STEP_SIZE:   csr_prdata = 32'(cfg_ff.step_size);
         im2col_pkg::REG_OUT_ROWS:    csr_prdata = 32'(cfg_ff.out_rows);
         im2col_pkg::REG_OUT_COLS:    csr_prdata = 32'(cfg_ff.out_cols);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= im2col_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/im2col_ctrl.sv */
// ----------------------------------------------------------------------------
// im2col_ctrl
// Sequencer: takes one command at a time and walks the patch elements.
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_command,
   output logic                           req_stall,
   input  im2col_pkg::ctrl_stat_type      stat,
   output im2col_pkg::ctrl_cmd_type       cmd
);

   im2col_pkg::state_type state_ff;
   im2col_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         im2col_pkg::ST_IDLE: begin
            if (req_valid && (req_command == im2col_pkg::CMD_GATHER)) begin
               state_in = im2col_pkg::ST_RUN;
            end
         end
         im2col_pkg::ST_RUN: begin
            if (stat.slot_free && stat.elem_last) begin
               state_in = im2col_pkg::ST_IDLE;
            end
         end
         default: state_in = im2col_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         im2col_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         im2col_pkg::ST_RUN: begin
            cmd.issue = stat.slot_free;
         end
         default: begin
            req_stall = 1'b1;
            cmd       = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= im2col_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/im2col_dpath.sv */
// ----------------------------------------------------------------------------
// im2col_dpath
// Image store, patch coordinate walk, read stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_dpath #(
   parameter int MAX_ROWS     = im2col_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS     = im2col_pkg::DEF_MAX_COLS,
   parameter int MAX_CHANNELS = im2col_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL   = im2col_pkg::DEF_MAX_KERNEL
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  im2col_pkg::cfg_type        cfg,
   input  im2col_pkg::req_type        req_data,
   input  im2col_pkg::ctrl_cmd_type   cmd,
   output im2col_pkg::ctrl_stat_type  stat,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output im2col_pkg::rsp_type        rsp_data
);

   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int KW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int ADDR_W = CH_W + ROW_W + COL_W;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int PW     = im2col_pkg::POS_W;

   logic [31:0] mem [DEPTH];

   // Effective configuration
   logic [6:0]  rows_eff;
   logic [6:0]  cols_eff;
   logic [3:0]  kr_eff;
   logic [3:0]  kc_eff;
   logic        ch_ok;

   // Request decode
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              setup;
   logic [10:0]       row_prod;
   logic [10:0]       col_prod;
   logic [15:0]       cidx_prod;

   // Walk registers
   logic [CH_W-1:0]   ch_ff;
   logic              err_ff;
   logic [13:0]       cidx_ff;
   logic [3:0]        kr_ff;
   logic [3:0]        kc_ff;
   logic [KW-1:0]     i_ff,   i_in;
   logic [KW-1:0]     j_ff,   j_in;
   logic [5:0]        off_ff, off_in;
   logic signed [PW-1:0] sw_ff;
   logic signed [PW-1:0] h_ff, h_in;
   logic signed [PW-1:0] w_ff, w_in;
   logic              row_end;
   logic              in_image;
   logic [ADDR_W-1:0] rd_addr;

   // Read stage and output register
   logic        a_valid_ff, a_valid_in;
   logic [5:0]  a_off_ff;
   logic [13:0] a_cidx_ff;
   logic        a_pad_ff;
   logic        a_err_ff;
   logic        a_last_ff;
   logic [31:0] mem_rd_ff;
   logic        move;
   logic        o_valid_ff, o_valid_in;
   im2col_pkg::rsp_type o_ff;

   always_comb begin
      rows_eff = (32'(cfg.image_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : cfg.image_rows;
      cols_eff = (32'(cfg.image_cols) > MAX_COLS) ? 7'(MAX_COLS) : cfg.image_cols;
      if (cfg.kernel_rows == 4'd0) begin
         kr_eff = 4'd1;
      end else if (32'(cfg.kernel_rows) > MAX_KERNEL) begin
         kr_eff = 4'(MAX_KERNEL);
      end else begin
         kr_eff = cfg.kernel_rows;
      end
      if (cfg.kernel_cols == 4'd0) begin
         kc_eff = 4'd1;
      end else if (32'(cfg.kernel_cols) > MAX_KERNEL) begin
         kc_eff = 4'(MAX_KERNEL);
      end else begin
         kc_eff = cfg.kernel_cols;
      end
   end

   assign ch_ok   = (32'(req_data.channel) < MAX_CHANNELS);
   assign wr_en   = cmd.take && (req_data.command == im2col_pkg::CMD_WRITE) && ch_ok
                    && (req_data.row_index < rows_eff) && (req_data.col_index < cols_eff);
   assign wr_addr = {CH_W'(req_data.channel), ROW_W'(req_data.row_index),
                     COL_W'(req_data.col_index)};
   assign setup   = cmd.take && (req_data.command == im2col_pkg::CMD_GATHER);

   assign row_prod  = 11'(req_data.row_index) * 11'(cfg.step_size);
   assign col_prod  = 11'(req_data.col_index) * 11'(cfg.step_size);
   assign cidx_prod = 16'(req_data.row_index) * 16'(cfg.out_cols);

   // Current element
   assign row_end  = (4'(j_ff) + 4'd1 == kc_ff);
   assign in_image = !h_ff[PW-1] && !w_ff[PW-1]
                     && (h_ff < $signed(PW'(rows_eff))) && (w_ff < $signed(PW'(cols_eff)));
   assign rd_addr  = {ch_ff, ROW_W'(h_ff), COL_W'(w_ff)};

   assign stat.elem_last = err_ff || (row_end && (4'(i_ff) + 4'd1 == kr_ff));

   // Advance the walk one element, row-major
   always_comb begin
      i_in   = i_ff;
      j_in   = j_ff;
      h_in   = h_ff;
      w_in   = w_ff;
      off_in = off_ff;
      if (cmd.issue) begin
         off_in = off_ff + 6'd1;
         if (row_end) begin
            j_in = '0;
            i_in = i_ff + KW'(1);
            w_in = sw_ff;
            h_in = h_ff + PW'(1);
         end else begin
            j_in = j_ff + KW'(1);
            w_in = w_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (setup) begin
         ch_ff   <= CH_W'(req_data.channel);
         err_ff  <= !ch_ok || (8'(req_data.row_index) >= cfg.out_rows)
                    || (8'(req_data.col_index) >= cfg.out_cols);
         cidx_ff <= 14'(cidx_prod + 16'(req_data.col_index));
         kr_ff   <= kr_eff;
         kc_ff   <= kc_eff;
         i_ff    <= '0;
         j_ff    <= '0;
         off_ff  <= '0;
         h_ff    <= $signed({1'b0, row_prod}) - $signed(PW'(cfg.pad_amount));
         w_ff    <= $signed({1'b0, col_prod}) - $signed(PW'(cfg.pad_amount));
         sw_ff   <= $signed({1'b0, col_prod}) - $signed(PW'(cfg.pad_amount));
      end else begin
         i_ff   <= i_in;
         j_ff   <= j_in;
         off_ff <= off_in;
         h_ff   <= h_in;
         w_ff   <= w_in;
      end
   end

   // Image store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_data.write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue && in_image && !err_ff) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   // Read stage hands over when the output register is free or being taken
   assign move           = a_valid_ff && (!o_valid_ff || !rsp_stall);
   assign stat.slot_free = !a_valid_ff || move;
   assign a_valid_in     = cmd.issue || (a_valid_ff && !move);
   assign o_valid_in     = move || (o_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         a_off_ff  <= err_ff ? 6'd0 : off_ff;
         a_cidx_ff <= err_ff ? 14'd0 : cidx_ff;
         a_pad_ff  <= !err_ff && !in_image;
         a_err_ff  <= err_ff;
         a_last_ff <= stat.elem_last;
      end
      if (move) begin
         o_ff.pixel_word    <= (a_pad_ff || a_err_ff) ? 32'd0 : mem_rd_ff;
         o_ff.kernel_offset <= a_off_ff;
         o_ff.column_index  <= a_cidx_ff;
         o_ff.is_padding    <= a_pad_ff;
         o_ff.request_error <= a_err_ff;
         o_ff.last          <= a_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_ff;

endmodule

`default_nettype wire

/* hdl/im2col_patch_gather.sv */
// ----------------------------------------------------------------------------
// im2col_patch_gather
// Multi-channel image store with im2col patch readout.
// ----------------------------------------------------------------------------
// Request channel (req_valid, req_stall, req_data): a write word stores one
// pixel and gives no result; a gather word emits kernel_rows*kernel_cols
// result words on the rsp channel in row-major order, last set on the final
// one. A gather outside the configured output size, or to a channel at or
// above MAX_CHANNELS, gives one word with request_error and last set.
// A gather holds req_stall high from acceptance until its last element is
// issued; the single read port of the image store takes the elements one at
// a time. After acceptance the first result word passes the read stage and
// the output register before it is shown.
// A read stage and an output register part the store from the receiver;
// while rsp_stall is high the shown word holds and the walk pauses once the
// read stage is full.
// Configuration registers sit at byte address 4*index; it is for the user to
// see that they are written only while the block is idle; the block does not
// enforce it.
// Reset clears the registers to their defaults and empties the pipeline; the
// image store is not cleared and must be written before it is gathered.
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_patch_gather #(
   parameter int MAX_ROWS     = im2col_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS     = im2col_pkg::DEF_MAX_COLS,
   parameter int MAX_CHANNELS = im2col_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL   = im2col_pkg::DEF_MAX_KERNEL
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  im2col_pkg::req_type                    req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output im2col_pkg::rsp_type                    rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [im2col_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [im2col_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [im2col_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready
);

   im2col_pkg::cfg_type       cfg;
   im2col_pkg::ctrl_cmd_type  cmd;
   im2col_pkg::ctrl_stat_type stat;

   im2col_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   im2col_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   im2col_dpath #(
      .MAX_ROWS     (MAX_ROWS),
      .MAX_COLS     (MAX_COLS),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_KERNEL   (MAX_KERNEL)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* hdl/im2col_checker.sv */
// ----------------------------------------------------------------------------
// im2col_checker
// Port-level checks of the im2col patch gather, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input im2col_pkg::req_type                    req_data,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input im2col_pkg::rsp_type                    rsp_data
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // A rejected gather is a single, zeroed, final word
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.request_error |->
         rsp_data.last && !rsp_data.is_padding && (rsp_data.pixel_word == 32'd0)
         && (rsp_data.kernel_offset == 6'd0) && (rsp_data.column_index == 14'd0))
      else $error("malformed request error word");

   // Padding positions carry a zero word
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_padding |-> (rsp_data.pixel_word == 32'd0))
      else $error("padding word not zero");

   // An accepted gather holds off the next request word
   a_gather_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.command == im2col_pkg::CMD_GATHER)
      |=> req_stall)
      else $error("request taken straight after a gather");

endmodule

bind im2col_patch_gather im2col_checker u_im2col_checker (.*);

`default_nettype wire
